@@ rtl/core/sba_pkg.sv @@
// ============================================================================
// Segment bitmap allocator package
// Field widths and request and status codes shared by the allocator and its testbench.
// ============================================================================
package sba_pkg;

    localparam int KIND_W     = 2;
    localparam int SIZE_W     = 9;
    localparam int HANDLE_W   = 4;
    localparam int STATUS_W   = 2;
    localparam int START_W    = 4;
    localparam int COUNT_W    = 5;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESIZE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNKNOWN  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SIZE = 2'd3;

endpackage

@@ rtl/core/sba_ram.sv @@
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module sba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/sba_run_unit.sv @@
// ============================================================================
// Free run counter step
// Extends or breaks the current free run by one segment and flags a fit.
// ============================================================================
module sba_run_unit #(
    parameter int LW = 5
) (
    input  logic          used,
    input  logic [LW-1:0] run,
    input  logic [LW-1:0] need,
    output logic [LW-1:0] run_next,
    output logic          hit
);

    always_comb begin
        if (used) begin
            run_next = '0;
        end else begin
            run_next = LW'(run + 1'b1);
        end
        hit = !used && (run_next == need);
    end

endmodule

@@ rtl/core/segment_bitmap_allocator.sv @@
// ============================================================================
// Segment bitmap allocator
// First-fit allocator over a pool of fixed-size segments.
// ============================================================================
// Requests arrive on the s_ channel, one beat each: s_tuser carries the kind
// (allocate, free, resize) and s_tdata the byte size and the block handle.
// Every request gives exactly one result beat on the m_ channel with a status,
// the start segment and the segment count of the resulting block.
// A request first converts its byte size to segments by repeated subtraction,
// one segment per cycle, then reads the block length memory. Allocation and a
// growing resize scan the used bitmap one segment per cycle through the run
// counter, and every claimed or released segment is then marked one per cycle.
// s_tready is high only while the block is idle, which it returns to as each
// result is loaded into the output register. That register holds it, so a stalled
// receiver holds only the result beat; the next request is taken but its
// result waits until the previous beat is accepted.
// Reset clears the bitmap and all block valid flags, so every segment is free.
// ============================================================================
module segment_bitmap_allocator #(
    parameter int SEGMENTS      = 16,
    parameter int SEGMENT_BYTES = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: size_bytes[8:0], handle[12:9], zero fill.
    input  logic [sba_pkg::IN_DATA_W-1:0]   s_tdata,
    // Fields from bit 0: kind[1:0].
    input  logic [sba_pkg::KIND_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0: status[1:0], start_segment[5:2], segment_count[10:6], zero fill.
    output logic [sba_pkg::OUT_DATA_W-1:0]  m_tdata
);

    import sba_pkg::*;

    localparam int IW        = $clog2(SEGMENTS);
    localparam int LW        = $clog2(SEGMENTS + 1);
    localparam int MAX_BYTES = SEGMENTS * SEGMENT_BYTES;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DIV    = 6'b000010,
        ST_LOOKUP = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_MARK   = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic                size_bad_reg, size_bad_next;
    logic [SIZE_W-1:0]   rem_reg, rem_next;
    logic [LW-1:0]       n_reg, n_next;
    logic [LW-1:0]       old_len_reg, old_len_next;
    logic [IW-1:0]       scan_idx_reg, scan_idx_next;
    logic [LW-1:0]       run_reg, run_next;
    logic [IW-1:0]       mk_idx_reg, mk_idx_next;
    logic [LW-1:0]       mk_left_reg, mk_left_next;
    logic                mk_val_reg, mk_val_next;
    logic                free_pend_reg, free_pend_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [IW-1:0]       res_start_reg, res_start_next;
    logic [LW-1:0]       res_count_reg, res_count_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [IW-1:0]       out_start_reg, out_start_next;
    logic [LW-1:0]       out_count_reg, out_count_next;
    logic [SEGMENTS-1:0] used_reg, used_next;
    logic [SEGMENTS-1:0] valid_reg, valid_next;

    logic [SIZE_W-1:0]   s_size;
    logic [HANDLE_W-1:0] s_handle;
    logic [IW-1:0]       h_idx;
    logic                h_ok;
    logic [IW-1:0]       found_start;
    logic [LW-1:0]       unit_run;
    logic                unit_hit;
    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic [LW-1:0]       ram_wdata;
    logic [LW-1:0]       ram_rdata;

    assign s_size   = s_tdata[SIZE_W-1:0];
    assign s_handle = s_tdata[SIZE_W+HANDLE_W-1:SIZE_W];
    assign h_idx    = IW'(handle_reg);
    assign h_ok     = (32'(handle_reg) < SEGMENTS) && valid_reg[h_idx];
    assign found_start = IW'(32'(scan_idx_reg) + 1 - 32'(n_reg));

    sba_run_unit #(
        .LW(LW)
    ) u_run (
        .used     (used_reg[scan_idx_reg]),
        .run      (run_reg),
        .need     (n_reg),
        .run_next (unit_run),
        .hit      (unit_hit)
    );

    sba_ram #(
        .WIDTH(LW),
        .DEPTH(SEGMENTS)
    ) u_len_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (h_idx),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        handle_next     = handle_reg;
        size_bad_next   = size_bad_reg;
        rem_next        = rem_reg;
        n_next          = n_reg;
        old_len_next    = old_len_reg;
        scan_idx_next   = scan_idx_reg;
        run_next        = run_reg;
        mk_idx_next     = mk_idx_reg;
        mk_left_next    = mk_left_reg;
        mk_val_next     = mk_val_reg;
        free_pend_next  = free_pend_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_count_next  = res_count_reg;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        out_count_next  = out_count_reg;
        used_next       = used_reg;
        valid_next      = valid_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;

        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next     = s_tuser;
                    handle_next   = s_handle;
                    rem_next      = s_size;
                    n_next        = '0;
                    size_bad_next = (s_size == '0) || (32'(s_size) > MAX_BYTES);
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (size_bad_reg || (rem_reg == '0)) begin
                    state_next = ST_LOOKUP;
                end else if (32'(rem_reg) <= SEGMENT_BYTES) begin
                    rem_next   = '0;
                    n_next     = LW'(n_reg + 1'b1);
                    state_next = ST_LOOKUP;
                end else begin
                    rem_next = SIZE_W'(32'(rem_reg) - SEGMENT_BYTES);
                    n_next   = LW'(n_reg + 1'b1);
                end
            end
            ST_LOOKUP: begin
                old_len_next    = ram_rdata;
                res_status_next = STATUS_OK;
                res_start_next  = '0;
                res_count_next  = '0;
                free_pend_next  = 1'b0;
                scan_idx_next   = '0;
                run_next        = '0;
                state_next      = ST_FINISH;
                case (kind_reg)
                    KIND_ALLOC: begin
                        if (size_bad_reg) begin
                            res_status_next = STATUS_BAD_SIZE;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end
                    KIND_FREE: begin
                        if (!h_ok) begin
                            res_status_next = STATUS_UNKNOWN;
                        end else begin
                            mk_idx_next       = h_idx;
                            mk_left_next      = ram_rdata;
                            mk_val_next       = 1'b0;
                            valid_next[h_idx] = 1'b0;
                            res_start_next    = h_idx;
                            state_next        = ST_MARK;
                        end
                    end
                    KIND_RESIZE: begin
                        if (!h_ok) begin
                            res_status_next = STATUS_UNKNOWN;
                        end else if (size_bad_reg) begin
                            res_status_next = STATUS_BAD_SIZE;
                        end else if (n_reg <= ram_rdata) begin
                            mk_idx_next    = IW'(32'(h_idx) + 32'(n_reg));
                            mk_left_next   = LW'(ram_rdata - n_reg);
                            mk_val_next    = 1'b0;
                            ram_we         = 1'b1;
                            ram_waddr      = h_idx;
                            ram_wdata      = n_reg;
                            res_start_next = h_idx;
                            res_count_next = n_reg;
                            state_next     = ST_MARK;
                        end else begin
                            free_pend_next = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    default: begin
                        res_status_next = STATUS_BAD_SIZE;
                    end
                endcase
            end
            ST_SCAN: begin
                run_next = unit_run;
                if (unit_hit) begin
                    mk_idx_next             = found_start;
                    mk_left_next            = n_reg;
                    mk_val_next             = 1'b1;
                    valid_next[found_start] = 1'b1;
                    ram_we                  = 1'b1;
                    ram_waddr               = found_start;
                    ram_wdata               = n_reg;
                    res_start_next          = found_start;
                    res_count_next          = n_reg;
                    state_next              = ST_MARK;
                end else if (32'(scan_idx_reg) == SEGMENTS - 1) begin
                    res_status_next = STATUS_NO_SPACE;
                    free_pend_next  = 1'b0;
                    state_next      = ST_FINISH;
                end else begin
                    scan_idx_next = IW'(scan_idx_reg + 1'b1);
                end
            end
            ST_MARK: begin
                if (mk_left_reg != '0) begin
                    used_next[mk_idx_reg] = mk_val_reg;
                    mk_idx_next           = IW'(mk_idx_reg + 1'b1);
                    mk_left_next          = LW'(mk_left_reg - 1'b1);
                end else if (free_pend_reg) begin
                    free_pend_next    = 1'b0;
                    mk_idx_next       = h_idx;
                    mk_left_next      = old_len_reg;
                    mk_val_next       = 1'b0;
                    valid_next[h_idx] = 1'b0;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_status_next = res_status_reg;
                    out_start_next  = res_start_reg;
                    out_count_next  = res_count_reg;
                    m_tvalid_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            free_pend_reg <= 1'b0;
            used_reg      <= '0;
            valid_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            m_tvalid_reg  <= m_tvalid_next;
            free_pend_reg <= free_pend_next;
            used_reg      <= used_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        handle_reg     <= handle_next;
        size_bad_reg   <= size_bad_next;
        rem_reg        <= rem_next;
        n_reg          <= n_next;
        old_len_reg    <= old_len_next;
        scan_idx_reg   <= scan_idx_next;
        run_reg        <= run_next;
        mk_idx_reg     <= mk_idx_next;
        mk_left_reg    <= mk_left_next;
        mk_val_reg     <= mk_val_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_count_reg  <= res_count_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
        out_count_reg  <= out_count_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {
        (OUT_DATA_W - STATUS_W - START_W - COUNT_W)'(0),
        COUNT_W'(out_count_reg),
        START_W'(out_start_reg),
        out_status_reg
    };

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for the segment bitmap allocator
// Drives allocate, free, resize and unused-kind requests with random gaps
// and receiver stalls. Each result beat is checked against an in-bench
// first-fit model of the used bitmap and the block table.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sba_pkg::*;

    localparam int SEGS        = 16;
    localparam int SEG_BYTES   = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int MAX_REPORTS = 10;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [SIZE_W-1:0]   size_bytes;
        logic [HANDLE_W-1:0] handle;
    } alloc_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [START_W-1:0]  seg_start;
        logic [COUNT_W-1:0]  seg_count;
    } alloc_res_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // Fields from bit 0: size_bytes[8:0], handle[12:9], zero fill.
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    // Fields from bit 0: kind[1:0].
    logic [KIND_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // Fields from bit 0: status[1:0], start_segment[5:2], segment_count[10:6], zero fill.
    logic [OUT_DATA_W-1:0] m_tdata;

    alloc_req_t req_pending[$];
    alloc_res_t results_due[$];

    logic [SEGS-1:0] seg_used  = '0;
    logic [SEGS-1:0] blk_valid = '0;
    logic [COUNT_W-1:0] blk_len [SEGS];

    int  mismatches  = 0;
    int  idle_cycles = 0;
    int  tx_gap      = 0;
    int  rx_gap      = 0;
    int  rx_hold     = 0;
    int  hold_asks   = 0;
    int  hold_taken  = 0;
    bit  tx_calm     = 1'b0;
    bit  rx_calm     = 1'b0;

    segment_bitmap_allocator #(
        .SEGMENTS      (SEGS),
        .SEGMENT_BYTES (SEG_BYTES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        for (int i = 0; i < SEGS; i++) blk_len[i] = '0;
    end

    function automatic int first_fit(int n);
        int run;
        run = 0;
        for (int i = 0; i < SEGS; i++) begin
            if (seg_used[i]) begin
                run = 0;
            end else begin
                run++;
                if (run == n) return i - n + 1;
            end
        end
        return -1;
    endfunction

    function automatic void set_used(int first, int n, logic v);
        for (int i = first; i < first + n && i < SEGS; i++) seg_used[i] = v;
    endfunction

    function automatic int claim_run(int n);
        int s;
        s = first_fit(n);
        if (s >= 0) begin
            set_used(s, n, 1'b1);
            blk_valid[s] = 1'b1;
            blk_len[s]   = COUNT_W'(n);
        end
        return s;
    endfunction

    function automatic void release_block(int h);
        set_used(h, int'(blk_len[h]), 1'b0);
        blk_valid[h] = 1'b0;
        blk_len[h]   = '0;
    endfunction

    function automatic alloc_res_t serve_request(alloc_req_t q);
        alloc_res_t res;
        int  n;
        int  s;
        int  old;
        int  h;
        bit  size_bad;
        bit  handle_ok;
        res       = '{status: STATUS_OK, seg_start: '0, seg_count: '0};
        h         = int'(q.handle);
        n         = (int'(q.size_bytes) + SEG_BYTES - 1) / SEG_BYTES;
        size_bad  = (q.size_bytes == 0) || (n > SEGS);
        handle_ok = (h < SEGS) && blk_valid[h];
        case (q.kind)
            KIND_ALLOC: begin
                if (size_bad) begin
                    res.status = STATUS_BAD_SIZE;
                end else begin
                    s = claim_run(n);
                    if (s < 0) begin
                        res.status = STATUS_NO_SPACE;
                    end else begin
                        res.seg_start = START_W'(s);
                        res.seg_count = COUNT_W'(n);
                    end
                end
            end
            KIND_FREE: begin
                if (!handle_ok) begin
                    res.status = STATUS_UNKNOWN;
                end else begin
                    release_block(h);
                    res.seg_start = START_W'(h);
                end
            end
            KIND_RESIZE: begin
                if (!handle_ok) begin
                    res.status = STATUS_UNKNOWN;
                end else if (size_bad) begin
                    res.status = STATUS_BAD_SIZE;
                end else begin
                    old = int'(blk_len[h]);
                    if (n <= old) begin
                        set_used(h + n, old - n, 1'b0);
                        blk_len[h]    = COUNT_W'(n);
                        res.seg_start = START_W'(h);
                        res.seg_count = COUNT_W'(n);
                    end else begin
                        s = claim_run(n);
                        if (s < 0) begin
                            res.status = STATUS_NO_SPACE;
                        end else begin
                            release_block(h);
                            res.seg_start = START_W'(s);
                            res.seg_count = COUNT_W'(n);
                        end
                    end
                end
            end
            default: begin
                res.status = STATUS_BAD_SIZE;
            end
        endcase
        return res;
    endfunction

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic alloc_req_t make_req(logic [KIND_W-1:0] kind, int size_bytes, int handle);
        alloc_req_t q;
        q.kind       = kind;
        q.size_bytes = SIZE_W'(size_bytes);
        q.handle     = HANDLE_W'(handle);
        return q;
    endfunction

    function automatic alloc_req_t random_request();
        alloc_req_t q;
        int r;
        int n;
        int live[$];
        for (int i = 0; i < SEGS; i++) begin
            if (blk_valid[i]) live.push_back(i);
        end
        r = $urandom_range(0, 99);
        if (r < 42) q.kind = KIND_ALLOC;
        else if (r < 68) q.kind = KIND_FREE;
        else if (r < 97) q.kind = KIND_RESIZE;
        else q.kind = KIND_UNUSED;
        if (live.size() > 0 && $urandom_range(0, 99) < 85) begin
            q.handle = HANDLE_W'(live[$urandom_range(0, live.size() - 1)]);
        end else begin
            q.handle = HANDLE_W'($urandom_range(0, SEGS - 1));
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            q.size_bytes = '0;
        end else if (r < 8) begin
            q.size_bytes = SIZE_W'($urandom_range(SEGS * SEG_BYTES + 1, 511));
        end else if (r < 12) begin
            q.size_bytes = SIZE_W'(SEGS * SEG_BYTES);
        end else begin
            n = (r < 80) ? $urandom_range(1, 4) : $urandom_range(1, SEGS);
            q.size_bytes = SIZE_W'(n * SEG_BYTES - $urandom_range(0, SEG_BYTES - 1));
        end
        return q;
    endfunction

    always @(posedge aclk) begin : drive_requests
        alloc_req_t q;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            tx_gap   <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (tx_gap > 0) begin
                tx_gap   <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end else if (req_pending.size() > 0) begin
                q = req_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{(IN_DATA_W - SIZE_W - HANDLE_W){1'b0}}, q.handle, q.size_bytes};
                s_tuser  <= q.kind;
                tx_gap   <= pick_gap(tx_calm);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : drive_ready
        int g;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
            rx_hold  <= 0;
        end else if (rx_hold > 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= (rx_hold == 1);
        end else if (hold_asks != hold_taken) begin
            hold_taken <= hold_asks;
            rx_hold    <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap   <= rx_gap - 1;
            m_tready <= (rx_gap == 1);
        end else if (m_tvalid && m_tready) begin
            g = pick_gap(rx_calm);
            rx_gap   <= g;
            m_tready <= (g == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        alloc_req_t q;
        alloc_res_t got;
        alloc_res_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                q.kind       = s_tuser;
                q.size_bytes = s_tdata[SIZE_W-1:0];
                q.handle     = s_tdata[SIZE_W +: HANDLE_W];
                results_due.push_back(serve_request(q));
            end
            if (m_tvalid && m_tready) begin
                got.status    = m_tdata[STATUS_W-1:0];
                got.seg_start = m_tdata[STATUS_W +: START_W];
                got.seg_count = m_tdata[STATUS_W + START_W +: COUNT_W];
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected result beat: status %0d start %0d count %0d",
                                 got.status, got.seg_start, got.seg_count);
                    end
                end else begin
                    want = results_due.pop_front();
                    if (want.status != got.status || want.seg_start != got.seg_start ||
                        want.seg_count != got.seg_count) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("result mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                     want.status, want.seg_start, want.seg_count,
                                     got.status, got.seg_start, got.seg_count);
                        end
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("segment_bitmap_allocator verification failed");
                $finish;
            end
        end
    end

    task automatic wait_room();
        while (req_pending.size() >= 2) @(negedge aclk);
    endtask

    task automatic feed(alloc_req_t q);
        wait_room();
        req_pending.push_back(q);
    endtask

    task automatic feed_random(int n);
        repeat (n) begin
            wait_room();
            req_pending.push_back(random_request());
        end
    endtask

    task automatic wait_drained();
        while (req_pending.size() != 0 || s_tvalid || results_due.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        feed(make_req(KIND_ALLOC, 1, 0));
        feed(make_req(KIND_ALLOC, 16, 0));
        feed(make_req(KIND_ALLOC, 17, 0));
        feed(make_req(KIND_ALLOC, 0, 0));
        feed(make_req(KIND_ALLOC, 257, 0));
        feed(make_req(KIND_ALLOC, 511, 15));
        feed(make_req(KIND_FREE, 0, 15));
        feed(make_req(KIND_RESIZE, 0, 14));
        feed(make_req(KIND_RESIZE, 0, 2));
        feed(make_req(KIND_RESIZE, 32, 2));
        feed(make_req(KIND_RESIZE, 5, 2));
        feed(make_req(KIND_RESIZE, 48, 0));
        feed(make_req(KIND_UNUSED, 511, 15));
        feed(make_req(KIND_ALLOC, 256, 0));
        feed(make_req(KIND_RESIZE, 256, 1));
        feed(make_req(KIND_FREE, 0, 3));
        feed(make_req(KIND_FREE, 0, 1));
        feed(make_req(KIND_FREE, 0, 2));
        feed(make_req(KIND_ALLOC, 256, 0));
        feed(make_req(KIND_ALLOC, 1, 0));
        feed(make_req(KIND_RESIZE, 240, 0));
        feed(make_req(KIND_ALLOC, 16, 0));
        feed(make_req(KIND_FREE, 0, 0));
        feed(make_req(KIND_FREE, 0, 15));
        wait_drained();

        feed_random(450);
        wait_drained();

        tx_calm = 1'b1;
        hold_asks++;
        feed_random(40);
        tx_calm = 1'b0;
        wait_drained();

        tx_calm = 1'b1;
        rx_calm = 1'b1;
        feed_random(400);
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        feed_random(200);
        hold_asks++;
        feed_random(240);

        wait_drained();
        repeat (60) @(negedge aclk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("segment_bitmap_allocator verification clean");
        end else begin
            $display("segment_bitmap_allocator verification failed");
        end
        $finish;
    end

endmodule
